FILE: design/wtsp_pkg.sv
package wtsp_pkg;

    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 15;
    localparam int DIV_N_W = 64;
    localparam int ACC_W   = 64;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;
    localparam logic MAT_VIEW     = 1'b0;
    localparam logic MAT_PROJ     = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               which_matrix;
        logic [1:0]         entry_row;
        logic [1:0]         entry_col;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pix_x;
        logic signed [31:0] pix_y;
        logic               w_was_zero;
    } out_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VIEW,
        S_PROJ,
        S_WCHK,
        S_DIV,
        S_SCALE,
        S_FIN
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: design/wtsp_lane.sv
module wtsp_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wtsp_pkg::lane_ctrl_t    ctrl,
    input  logic signed [31:0]      m,
    input  logic signed [31:0]      v,
    output logic signed [31:0]      result
);

    logic signed [63:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [63:0] acc_reg, acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clr) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + (prod_reg >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctrl.mul_en;
            acc_reg      <= acc_next;
        end
        prod_reg <= m * v;
    end

    assign result = wtsp_pkg::sat32(acc_reg);

endmodule

FILE: design/wtsp_div.sv
module wtsp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    localparam int CNT_W = $clog2(wtsp_pkg::DIV_N_W);

    logic [63:0]      q_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      d_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [32:0] rem_sh;
    logic        fits;
    logic [63:0] n_mag;
    logic [31:0] d_mag;

    always_comb begin
        n_mag  = dividend[63] ? 64'(-dividend) : 64'(dividend);
        d_mag  = divisor[31] ? 32'(-divisor) : 32'(divisor);
        rem_sh = {rem_reg[31:0], q_reg[63]};
        fits   = rem_sh >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(wtsp_pkg::DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg   <= n_mag;
            rem_reg <= '0;
            d_reg   <= d_mag;
            neg_reg <= dividend[63] ^ divisor[31];
        end else if (busy_reg) begin
            q_reg   <= {q_reg[62:0], fits};
            rem_reg <= fits ? rem_sh - {1'b0, d_reg} : rem_sh;
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quotient = (q_reg > 64'h7fffffff) ? 32'sh7fffffff : q_reg[31:0];
        end else begin
            quotient = (q_reg >= 64'h80000000) ? 32'sh80000000 : 32'(-q_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

FILE: design/world_to_screen_projection.sv
// Load transfer: accepted while idle, no result.
// Project transfer: two matrix passes on four row lanes, a 64-step radix-2 divider
// for x/w and y/w, one scaling multiply and the output register (divider and
// scaling skipped when clip w is zero). A new transfer is accepted only when idle,
// after the previous result has been loaded into the output register.
// Reset (aresetn, synchronous, active low) clears control; viewport = 1920x1080.
module world_to_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wtsp_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wtsp_pkg::out_t     m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [14:0]        cfg_wdata
);

    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [49:0] BIAS = (50'sd1 <<< (FRAC_BITS + 1)) - 50'sd1;

    wtsp_pkg::state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [14:0] width_reg, height_reg;

    logic signed [31:0] view_reg [16];
    logic signed [31:0] proj_reg [16];
    logic signed [31:0] vec_reg  [4];
    logic signed [31:0] lane_out [4];
    logic signed [31:0] lane_m   [4];
    logic signed [31:0] lane_v;
    wtsp_pkg::lane_ctrl_t lane_ctrl;

    logic               m_valid_reg;
    wtsp_pkg::out_t     m_data_reg;
    logic signed [31:0] ndc_x_reg, ndc_y_reg;
    logic signed [49:0] scl_x_reg, scl_y_reg;
    logic               wz_reg;

    logic               accept, latch_vec, div_start, out_load;
    logic               dx_done, dy_done;
    logic signed [31:0] dx_q, dy_q;
    logic signed [49:0] tx, ty;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wtsp_pkg::S_IDLE;
            cnt_reg     <= '0;
            width_reg   <= 15'd1920;
            height_reg  <= 15'd1080;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && cfg_addr == wtsp_pkg::CFG_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == wtsp_pkg::CFG_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        latch_vec  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        lane_ctrl  = '{clr: 1'b0, mul_en: 1'b0};
        case (state_reg)
            wtsp_pkg::S_IDLE: begin
                s_ready       = 1'b1;
                lane_ctrl.clr = 1'b1;
                cnt_next      = '0;
                if (s_valid && s_data.kind == wtsp_pkg::KIND_PROJECT) begin
                    state_next = wtsp_pkg::S_VIEW;
                end
            end
            wtsp_pkg::S_VIEW, wtsp_pkg::S_PROJ: begin
                lane_ctrl.mul_en = !cnt_reg[2];
                cnt_next         = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    latch_vec     = 1'b1;
                    lane_ctrl.clr = 1'b1;
                    cnt_next      = '0;
                    state_next    = (state_reg == wtsp_pkg::S_VIEW) ?
                                    wtsp_pkg::S_PROJ : wtsp_pkg::S_WCHK;
                end
            end
            wtsp_pkg::S_WCHK: begin
                if (vec_reg[3] == 32'sd0) begin
                    state_next = wtsp_pkg::S_FIN;
                end else begin
                    div_start  = 1'b1;
                    state_next = wtsp_pkg::S_DIV;
                end
            end
            wtsp_pkg::S_DIV: begin
                if (dx_done) begin
                    state_next = wtsp_pkg::S_SCALE;
                end
            end
            wtsp_pkg::S_SCALE: begin
                state_next = wtsp_pkg::S_FIN;
            end
            wtsp_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = wtsp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wtsp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.kind == wtsp_pkg::KIND_LOAD) begin
            if (s_data.which_matrix == wtsp_pkg::MAT_VIEW) begin
                view_reg[{s_data.entry_row, s_data.entry_col}] <= s_data.entry_value;
            end else begin
                proj_reg[{s_data.entry_row, s_data.entry_col}] <= s_data.entry_value;
            end
        end
        if (accept) begin
            vec_reg[0] <= s_data.point_x;
            vec_reg[1] <= s_data.point_y;
            vec_reg[2] <= s_data.point_z;
            vec_reg[3] <= ONE;
        end else if (latch_vec) begin
            for (int r = 0; r < 4; r++) begin
                vec_reg[r] <= lane_out[r];
            end
        end
        if (state_reg == wtsp_pkg::S_WCHK) begin
            wz_reg <= (vec_reg[3] == 32'sd0);
        end
        if (dx_done) begin
            ndc_x_reg <= dx_q;
            ndc_y_reg <= dy_q;
        end
        if (state_reg == wtsp_pkg::S_SCALE) begin
            scl_x_reg <= 50'((33'(ndc_x_reg) + 33'(ONE)) * $signed({1'b0, width_reg}));
            scl_y_reg <= 50'((33'(ndc_y_reg) + 33'(ONE)) * $signed({1'b0, height_reg}));
        end
        if (out_load) begin
            m_data_reg.w_was_zero <= wz_reg;
            m_data_reg.pix_x      <= wz_reg ? 32'sd0 :
                                     wtsp_pkg::sat32(64'(tx >>> (FRAC_BITS + 1)));
            m_data_reg.pix_y      <= wz_reg ? 32'sd0 :
                                     wtsp_pkg::sat32(64'(ty >>> (FRAC_BITS + 1)));
        end
    end

    assign tx = scl_x_reg + (scl_x_reg[49] ? BIAS : 50'sd0);
    assign ty = scl_y_reg + (scl_y_reg[49] ? BIAS : 50'sd0);

    assign lane_v = vec_reg[cnt_reg[1:0]];

    for (genvar r = 0; r < 4; r++) begin : g_lane
        assign lane_m[r] = (state_reg == wtsp_pkg::S_PROJ) ?
                           proj_reg[{2'(r), cnt_reg[1:0]}] :
                           view_reg[{2'(r), cnt_reg[1:0]}];
        wtsp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .m       (lane_m[r]),
            .v       (lane_v),
            .result  (lane_out[r])
        );
    end

    wtsp_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (64'(vec_reg[0]) <<< FRAC_BITS),
        .divisor  (vec_reg[3]),
        .done     (dx_done),
        .quotient (dx_q)
    );

    wtsp_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (64'(vec_reg[1]) <<< FRAC_BITS),
        .divisor  (vec_reg[3]),
        .done     (dy_done),
        .quotient (dy_q)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_done == dy_done)
        else $error("divider lanes out of step");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd5)
        else $error("pass counter out of range");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == wtsp_pkg::S_FIN))
        else $error("result raised outside final state");

    a_zero_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.w_was_zero |-> m_data.pix_x == 32'sd0 &&
        m_data.pix_y == 32'sd0)
        else $error("zero w result not cleared");

endmodule
